>>> src/dpr_pkg.sv
// Shared types and constants for the debug packet receiver.
// No dependencies; imported by every module of the block.
package dpr_pkg;

  localparam int LEN_W = 9;

  localparam logic [7:0] CH_DOLLAR = 8'h24;  // '$'
  localparam logic [7:0] CH_HASH   = 8'h23;  // '#'
  localparam logic [7:0] CH_0      = 8'h30;  // '0'
  localparam logic [7:0] CH_9      = 8'h39;  // '9'
  localparam logic [7:0] CH_LA     = 8'h61;  // 'a'
  localparam logic [7:0] CH_LF     = 8'h66;  // 'f'
  localparam logic [7:0] CH_UA     = 8'h41;  // 'A'
  localparam logic [7:0] CH_UF     = 8'h46;  // 'F'
  localparam logic [7:0] HEX_TEN   = 8'd10;

  typedef enum logic [1:0] {
    PH_HUNT    = 2'd0,
    PH_PAYLOAD = 2'd1,
    PH_HIGH    = 2'd2,
    PH_LOW     = 2'd3
  } phase_t;

  typedef enum logic [2:0] {
    EV_PAYLOAD = 3'd0,
    EV_FULL    = 3'd1,
    EV_RESTART = 3'd2,
    EV_GOOD    = 3'd3,
    EV_BAD     = 3'd4
  } event_kind_t;

  typedef struct packed {
    logic             valid;
    event_kind_t      kind;
    logic [7:0]       data;
    logic [LEN_W-1:0] length;
    logic [7:0]       sum;
  } evt_t;

endpackage

>>> src/dpr_hex_decode.sv
// Hex digit decoder for the checksum characters.
// Depends on dpr_pkg for the character constants.
module dpr_hex_decode import dpr_pkg::*; (
  input  logic [7:0] ch,
  output logic       ok,
  output logic [3:0] value
);

  logic [7:0] diff;

  always_comb begin
    ok   = 1'b1;
    diff = 8'd0;
    if (ch >= CH_LA && ch <= CH_LF) begin
      diff = ch - CH_LA + HEX_TEN;
    end else if (ch >= CH_0 && ch <= CH_9) begin
      diff = ch - CH_0;
    end else if (ch >= CH_UA && ch <= CH_UF) begin
      diff = ch - CH_UA + HEX_TEN;
    end else begin
      ok = 1'b0;
    end
    value = diff[3:0];
  end

endmodule

>>> src/dpr_step.sv
// Packet parser state and per-byte update: phase, running sum, count, high digit.
// Depends on dpr_pkg and dpr_hex_decode.
module dpr_step import dpr_pkg::*; #(
  parameter int BUFFER_SIZE = 512
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       accept,
  input  logic [7:0] rx_byte,
  output evt_t       evt
);

  localparam int CNT_W = $clog2(BUFFER_SIZE);
  localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(BUFFER_SIZE - 1);

  phase_t           phase, phase_next;
  logic [7:0]       running_sum, running_sum_next;
  logic [CNT_W-1:0] byte_count, byte_count_next;
  logic [3:0]       high_digit, high_digit_next;

  logic             dig_ok;
  logic [3:0]       dig_val;
  logic [7:0]       sum_add;
  logic [CNT_W-1:0] cnt_inc;
  logic [7:0]       recv_sum;
  logic [CNT_W+LEN_W-1:0] cnt_ext;

  dpr_hex_decode u_hex (
    .ch    (rx_byte),
    .ok    (dig_ok),
    .value (dig_val)
  );

  assign sum_add  = running_sum + rx_byte;
  assign cnt_inc  = byte_count + CNT_W'(1);
  assign recv_sum = {high_digit, 4'd0} + (dig_ok ? {4'd0, dig_val} : 8'hFF);

  // Next phase
  always_comb begin
    phase_next = phase;
    case (phase)
      PH_HUNT: begin
        if (rx_byte == CH_DOLLAR) phase_next = PH_PAYLOAD;
      end
      PH_PAYLOAD: begin
        if (rx_byte == CH_HASH) phase_next = PH_HIGH;
        else if (rx_byte != CH_DOLLAR && cnt_inc == FULL_COUNT) phase_next = PH_HUNT;
      end
      PH_HIGH: phase_next = PH_LOW;
      PH_LOW:  phase_next = PH_HUNT;
      default: phase_next = PH_HUNT;
    endcase
  end

  // Data registers and event
  always_comb begin
    running_sum_next = running_sum;
    byte_count_next  = byte_count;
    high_digit_next  = high_digit;
    evt.valid        = 1'b0;
    evt.kind         = EV_PAYLOAD;
    evt.data         = 8'd0;
    case (phase)
      PH_HUNT: begin
        if (rx_byte == CH_DOLLAR) begin
          running_sum_next = 8'd0;
          byte_count_next  = '0;
        end
      end
      PH_PAYLOAD: begin
        if (rx_byte == CH_DOLLAR) begin
          running_sum_next = 8'd0;
          byte_count_next  = '0;
          evt.valid        = 1'b1;
          evt.kind         = EV_RESTART;
        end else if (rx_byte != CH_HASH) begin
          running_sum_next = sum_add;
          byte_count_next  = cnt_inc;
          evt.valid        = 1'b1;
          evt.kind         = (cnt_inc == FULL_COUNT) ? EV_FULL : EV_PAYLOAD;
          evt.data         = rx_byte;
        end
      end
      PH_HIGH: begin
        high_digit_next = dig_ok ? dig_val : 4'hF;
      end
      PH_LOW: begin
        evt.valid = 1'b1;
        evt.kind  = (recv_sum == running_sum) ? EV_GOOD : EV_BAD;
      end
      default: ;
    endcase
    // Length and sum reported are the values after this byte
    cnt_ext    = {{LEN_W{1'b0}}, byte_count_next};
    evt.length = cnt_ext[LEN_W-1:0];
    evt.sum    = running_sum_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_HUNT;
      running_sum <= 8'd0;
      byte_count  <= '0;
      high_digit  <= 4'd0;
    end else if (accept) begin
      phase       <= phase_next;
      running_sum <= running_sum_next;
      byte_count  <= byte_count_next;
      high_digit  <= high_digit_next;
    end
  end

endmodule

>>> src/debug_packet_receiver_unit.sv
// Top level of the debug packet receiver: parser plus output register.
// Depends on dpr_pkg and dpr_step (which uses dpr_hex_decode).
//
//   channel | handshake           | payload
//   --------+---------------------+-------------------------------------------
//   input   | in_valid / in_ready | rx_byte[7:0]
//   output  | out_valid/out_ready | event_kind[2:0], payload_byte[7:0],
//           |                     | payload_length[8:0], computed_sum[7:0]
//
// The parser state updates at the accepting edge and any event lands in the
// output register at that same edge, so it shows in the following cycle. The
// sustained rate is one byte per clock while the downstream keeps up.
// The output register is the only buffer: a new byte is taken whenever the
// register is empty or is being drained in the same cycle; a stalled
// downstream holds the input off. Reset (rst, synchronous) returns the
// parser to hunting with sum, count and high digit cleared, and empties
// the output register.
module debug_packet_receiver_unit import dpr_pkg::*; #(
  parameter int BUFFER_SIZE = 512
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [7:0]       rx_byte,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [2:0]       event_kind,
  output logic [7:0]       payload_byte,
  output logic [LEN_W-1:0] payload_length,
  output logic [7:0]       computed_sum
);

  logic in_accept;
  evt_t evt;
  evt_t out_reg;
  logic out_full;

  // Take a transaction when the output slot is free or is draining now.
  assign in_ready  = !out_full || out_ready;
  assign in_accept = in_valid && in_ready;

  dpr_step #(
    .BUFFER_SIZE (BUFFER_SIZE)
  ) u_step (
    .clk     (clk),
    .rst     (rst),
    .accept  (in_accept),
    .rx_byte (rx_byte),
    .evt     (evt)
  );

  // Output register: hold until taken, load the event of each accepted byte that produces one.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_full <= 1'b0;
    end else if (in_accept) begin
      out_full <= evt.valid;
    end else if (out_ready) begin
      out_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept && evt.valid) begin
      out_reg <= evt;
    end
  end

  assign out_valid      = out_full;
  assign event_kind     = out_reg.kind;
  assign payload_byte   = out_reg.data;
  assign payload_length = out_reg.length;
  assign computed_sum   = out_reg.sum;

endmodule
